@@ design/anup_pkg.sv @@
package anup_pkg;

  // Base codes held in the base_select register
  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_DEC  = 2'd1;
  localparam logic [1:0] BASE_HEX  = 2'd2;
  localparam logic [1:0] BASE_NONE = 2'd3;

  // Character codes the parser reacts to
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_X   = 8'h78;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UF  = 8'h46;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;

  // Digit value meaning "not a hex digit"
  localparam logic [4:0] DIGIT_NONE = 5'd16;
  localparam logic [4:0] DEC_RADIX  = 5'd10;

  // Queue depth between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One classified character
  typedef struct packed {
    logic [4:0] digit;    // 0..15, or DIGIT_NONE
    logic       is_term;  // NUL, LF or CR
    logic       is_x;     // lowercase x
    logic       last;     // last character of the string
  } chr_t;

endpackage

@@ design/anup_front.sv @@
module anup_front import anup_pkg::*; (
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output chr_t       chr
);

  logic [7:0] lo_off;

  always_comb begin
    lo_off = 8'd0;
    chr.digit = DIGIT_NONE;
    if (char_code inside {[CHAR_0:CHAR_9]}) begin
      lo_off = char_code - CHAR_0;
      chr.digit = lo_off[4:0];
    end else if (char_code inside {[CHAR_UA:CHAR_UF]}) begin
      lo_off = char_code - CHAR_UA + 8'd10;
      chr.digit = lo_off[4:0];
    end else if (char_code inside {[CHAR_LA:CHAR_LF_HEX]}) begin
      lo_off = char_code - CHAR_LA + 8'd10;
      chr.digit = lo_off[4:0];
    end
    chr.is_term = (char_code == CHAR_NUL) || (char_code == CHAR_LF) || (char_code == CHAR_CR);
    chr.is_x    = (char_code == CHAR_X);
    chr.last    = end_of_text;
  end

endmodule

@@ design/anup_queue.sv @@
module anup_queue import anup_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  chr_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output chr_t head_data
);

  chr_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/anup_back.sv @@
module anup_back import anup_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  base_select,
  input  logic        head_valid,
  input  chr_t        head_data,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_parsed_value,
  output logic        out_parse_ok
);

  logic [31:0] acc_r, acc_nxt;
  logic        hex_r, hex_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        stop_r, stop_nxt;
  logic        fail_r, fail_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] value_r, value_nxt;
  logic        ok_r, ok_nxt;

  logic        radix16;
  logic        bad_digit;
  logic [31:0] acc_scaled;

  assign pop = head_valid && (!out_valid_r || out_ready);

  assign radix16    = (base_select == BASE_HEX) || ((base_select == BASE_AUTO) && hex_r);
  assign bad_digit  = radix16 ? head_data.digit[4] : (head_data.digit >= DEC_RADIX);
  assign acc_scaled = radix16 ? {acc_r[27:0], 4'b0}
                              : ({acc_r[28:0], 3'b0} + {acc_r[30:0], 1'b0});

  always_comb begin
    acc_nxt  = acc_r;
    hex_nxt  = hex_r;
    stop_nxt = stop_r;
    fail_nxt = fail_r;
    pos_nxt  = pos_r;
    if (!stop_r) begin
      if (base_select == BASE_NONE) begin
        acc_nxt  = '0;
        fail_nxt = 1'b1;
        stop_nxt = 1'b1;
      end else if ((base_select == BASE_AUTO) && (pos_r == 2'd1) && (acc_r == '0)
                   && head_data.is_x) begin
        hex_nxt = 1'b1;
      end else if (head_data.is_term) begin
        stop_nxt = 1'b1;
      end else if (bad_digit) begin
        fail_nxt = 1'b1;
        stop_nxt = 1'b1;
      end else begin
        acc_nxt = acc_scaled + {28'b0, head_data.digit[3:0]};
      end
    end
    if (pos_r != 2'd2) begin
      pos_nxt = pos_r + 2'd1;
    end
    value_nxt = value_r;
    ok_nxt    = ok_r;
    if (head_data.last) begin
      value_nxt = acc_nxt;
      ok_nxt    = !fail_nxt;
      acc_nxt   = '0;
      hex_nxt   = 1'b0;
      stop_nxt  = 1'b0;
      fail_nxt  = 1'b0;
      pos_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && head_data.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      hex_r       <= 1'b0;
      pos_r       <= '0;
      stop_r      <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        acc_r  <= acc_nxt;
        hex_r  <= hex_nxt;
        pos_r  <= pos_nxt;
        stop_r <= stop_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_data.last) begin
      value_r <= value_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = value_r;
  assign out_parse_ok     = ok_r;

endmodule

@@ design/ascii_unsigned_number_parser.sv @@
// Flow: a character accepted into the queue is applied by the back end when it pops it;
//   popping a last character registers the result and sets out_valid.
// Throughput: one character per cycle unless a result held for out_ready stalls the
//   back end, set by its combinational shift-and-add by 10 or 16 and the two-entry queue.
// Reset (rst_n low, synchronous): queue empty, parse state cleared, base_select = auto.
module ascii_unsigned_number_parser import anup_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_parsed_value,
  output logic        out_parse_ok
);

  logic [1:0] base_select_r;
  chr_t       front_chr;
  chr_t       head_chr;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;

  // Config beat always taken; write it only while the block is idle (not enforced)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_select_r <= BASE_AUTO;
    end else if (cfg_valid) begin
      base_select_r <= cfg_data;
    end
  end

  // Front end: classify the character of each accepted beat
  anup_front u_front (
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .chr         (front_chr)
  );

  // Accept a beat whenever the queue has a free slot
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  anup_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (front_chr),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_chr)
  );

  // Back end: advance the accumulator, hold the result until taken
  anup_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .base_select      (base_select_r),
    .head_valid       (q_valid),
    .head_data        (head_chr),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_parsed_value (out_parsed_value),
    .out_parse_ok     (out_parse_ok)
  );

endmodule
